// File: sv/chtd_pkg.sv
// Package for the canonical Huffman tree decoder: widths, codes and word layouts.
`default_nettype none

package chtd_pkg;

    // Default sizes handed to the core parameters.
    localparam int DEF_MAX_SYMBOLS  = 288;
    localparam int DEF_MAX_CODE_LEN = 15;

    // Size of the DEFLATE literal/length alphabet; the core's reset alphabet size, capped to MAX_SYMBOLS.
    localparam int LIT_SYMBOLS = 288;

    // Field and state widths.
    localparam int CMD_W       = 2;
    localparam int SYM_W       = 9;
    localparam int LEN_W       = 4;
    localparam int CODE_W      = 16;
    localparam int TALLY_W     = 9;
    localparam int PTR_W       = 10;
    localparam int NUM_LENGTHS = 16;

    // Walk pointer value that lies outside every tree.
    localparam logic [PTR_W-1:0] OUTSIDE_PTR = '1;

    // Commands carried in s_tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BUILD  = 2'd1,
        CMD_DECODE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_OVERRUN  = 2'd1,
        STS_OUTSIDE  = 2'd2,
        STS_RESERVED = 2'd3
    } status_t;

    // Input word, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]       pad;
        logic             code_bit;
        logic [LEN_W-1:0] max_length;
        logic [SYM_W-1:0] code_count;
        logic [LEN_W-1:0] code_length;
        logic [SYM_W-1:0] symbol_index;
    } in_word_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]       pad;
        status_t          status;
        logic [SYM_W-1:0] decoded_symbol;
        logic             symbol_valid;
    } out_word_t;

    // One node table entry: a filled flag and a leaf symbol or link.
    typedef struct packed {
        logic             filled;
        logic [PTR_W-1:0] value;
    } node_entry_t;

endpackage

`default_nettype wire

// File: sv/canonical_huffman_tree_decoder_core.sv
// Canonical Huffman tree builder and bit-serial decoder built around two memories.
//
//  Channel | Ports                              | Word
//  --------+------------------------------------+---------------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser  | tuser: command; tdata: index, length, count,
//          |                                    |        max length, code bit
//  result  | m_tvalid m_tready m_tdata          | symbol_valid, decoded_symbol, status
//
// A load writes the code-length memory when taken; a decode is one node table read and its
// evaluation. A build clears 2*N node table entries, tallies the N code lengths, finds the
// first code of each length, then reads each symbol's length and inserts its code bit by bit,
// N being the alphabet size; the single node table port and the code-length memory read set
// this order. After reset all 2*MAX_SYMBOLS node table entries are cleared before any word.
// Only one word is worked on at a time; a finished result waits in the output register
// while the next word is taken, and a new result stalls until that register is free.
`default_nettype none

module canonical_huffman_tree_decoder_core
    import chtd_pkg::*;
#(
    parameter int MAX_SYMBOLS  = DEF_MAX_SYMBOLS,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [8:0] symbol_index, [12:9] code_length, [21:13] code_count,
    // [25:22] max_length, [26] code_bit, [31:27] zero
    input  wire logic [31:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] symbol_valid, [9:1] decoded_symbol, [11:10] status, [15:12] zero
    output logic [15:0]      m_tdata
);

    localparam int TABLE_SIZE = 2 * MAX_SYMBOLS;
    localparam int LS_AW      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int NT_AW      = LS_AW + 1;

    localparam logic [PTR_W:0]       MAX_SYM_V  = (PTR_W + 1)'(MAX_SYMBOLS);
    localparam logic [LEN_W-1:0]     MAX_LEN_V  = LEN_W'(MAX_CODE_LEN);
    localparam logic [SYM_W-1:0]     ALPHA_RST  =
        SYM_W'((MAX_SYMBOLS < LIT_SYMBOLS) ? MAX_SYMBOLS : LIT_SYMBOLS);
    localparam logic [NT_AW-1:0]     CLR_ALL    = NT_AW'(TABLE_SIZE - 1);
    localparam logic [LEN_W-1:0]     LAST_LEN   = LEN_W'(NUM_LENGTHS - 1);

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b000_0000_0001,
        ST_IDLE     = 11'b000_0000_0010,
        ST_TALLY    = 11'b000_0000_0100,
        ST_TALLY_END= 11'b000_0000_1000,
        ST_CODES    = 11'b000_0001_0000,
        ST_INS_LRD  = 11'b000_0010_0000,
        ST_INS_LEV  = 11'b000_0100_0000,
        ST_BIT_RD   = 11'b000_1000_0000,
        ST_BIT_EV   = 11'b001_0000_0000,
        ST_DEC_EV   = 11'b010_0000_0000,
        ST_RESP     = 11'b100_0000_0000
    } state_t;

    // Memories.
    logic [LEN_W-1:0] ls_mem [MAX_SYMBOLS];
    node_entry_t      nt_mem [TABLE_SIZE];

    // Registers.
    state_t            state_reg, state_next;
    logic [NT_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [NT_AW-1:0]  clr_last_reg, clr_last_next;
    logic              build_reg, build_next;
    logic              tv_reg, tv_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [SYM_W-1:0]  alpha_reg, alpha_next;
    logic [LEN_W-1:0]  ml_reg, ml_next;
    logic [SYM_W-1:0]  n_reg, n_next;
    logic [LEN_W-1:0]  b_reg, b_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  bi_reg, bi_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [PTR_W-1:0]  pos_reg, pos_next;
    logic [PTR_W-1:0]  nodes_reg, nodes_next;
    logic [NT_AW-1:0]  idx_reg, idx_next;
    logic [TALLY_W-1:0] tally_reg [NUM_LENGTHS];
    logic [TALLY_W-1:0] tally_next [NUM_LENGTHS];
    logic [CODE_W-1:0]  ncode_reg [NUM_LENGTHS];
    logic [CODE_W-1:0]  ncode_next [NUM_LENGTHS];
    out_word_t         res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;
    out_word_t         m_word_reg, m_word_next;

    // Memory ports.
    logic              ls_we, ls_re;
    logic [LS_AW-1:0]  ls_waddr, ls_raddr;
    logic [LEN_W-1:0]  ls_wdata;
    logic [LEN_W-1:0]  ls_rdata_reg;
    logic              nt_we, nt_re;
    logic [NT_AW-1:0]  nt_waddr, nt_raddr;
    node_entry_t       nt_wdata;
    node_entry_t       nt_rdata_reg;

    // Decoded input and helpers.
    in_word_t          in_word;
    cmd_t              in_cmd;
    logic              accept;
    logic              out_free;
    logic [SYM_W-1:0]  nc_sat;
    logic [LEN_W-1:0]  ml_sat;
    logic [LEN_W-1:0]  leff;
    logic [LEN_W-1:0]  b_prev;
    logic [LEN_W-1:0]  tally_idx;
    logic [LEN_W-1:0]  ncode_idx;
    logic [TALLY_W-1:0] tally_rd;
    logic [CODE_W-1:0]  ncode_rd;
    logic [LEN_W-1:0]  bit_sel;
    logic              cur_bit;
    logic              last_bit;
    logic              last_sym;
    logic [PTR_W-1:0]  alpha_ext;
    logic [PTR_W-1:0]  nodes_inc;
    logic              emit;
    out_word_t         emit_word;

    assign in_word  = in_word_t'(s_tdata[$bits(in_word_t)-1:0]);
    assign in_cmd   = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_word_reg;

    // Alphabet size clamped to 2..MAX_SYMBOLS and length limit clamped to MAX_CODE_LEN.
    always_comb begin
        priority if (in_word.code_count < SYM_W'(2)) begin
            nc_sat = SYM_W'(2);
        end else if ({1'b0, in_word.code_count} > MAX_SYM_V) begin
            nc_sat = SYM_W'(MAX_SYMBOLS);
        end else begin
            nc_sat = in_word.code_count;
        end
        ml_sat = (in_word.max_length > MAX_LEN_V) ? MAX_LEN_V : in_word.max_length;
    end

    // Effective length of the symbol just read: lengths above the limit count as unused.
    assign leff      = (ls_rdata_reg > ml_reg) ? '0 : ls_rdata_reg;
    assign b_prev    = b_reg - LEN_W'(1);
    assign tally_idx = (state_reg == ST_CODES) ? b_prev : leff;
    assign ncode_idx = (state_reg == ST_CODES) ? b_prev : leff;
    assign tally_rd  = tally_reg[tally_idx];
    assign ncode_rd  = ncode_reg[ncode_idx];
    assign bit_sel   = len_reg - LEN_W'(1) - bi_reg;
    assign cur_bit   = code_reg[bit_sel];
    assign last_bit  = (bi_reg == len_reg - LEN_W'(1));
    assign last_sym  = (n_reg == alpha_reg - SYM_W'(1));
    assign alpha_ext = {1'b0, alpha_reg};
    assign nodes_inc = nodes_reg + PTR_W'(1);

    // Sequencer: next state, memory controls and result generation.
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_last_next = clr_last_reg;
        build_next    = build_reg;
        tv_next       = 1'b0;
        wp_next       = wp_reg;
        alpha_next    = alpha_reg;
        ml_next       = ml_reg;
        n_next        = n_reg;
        b_next        = b_reg;
        len_next      = len_reg;
        bi_next       = bi_reg;
        code_next     = code_reg;
        pos_next      = pos_reg;
        nodes_next    = nodes_reg;
        idx_next      = idx_reg;
        tally_next    = tally_reg;
        ncode_next    = ncode_reg;
        res_next      = res_reg;
        ls_we         = 1'b0;
        ls_waddr      = in_word.symbol_index[LS_AW-1:0];
        ls_wdata      = in_word.code_length;
        ls_re         = 1'b0;
        ls_raddr      = n_reg[LS_AW-1:0];
        nt_we         = 1'b0;
        nt_waddr      = idx_reg;
        nt_wdata      = '0;
        nt_re         = 1'b0;
        nt_raddr      = {pos_reg[LS_AW-1:0], cur_bit};
        emit          = 1'b0;
        emit_word     = '0;

        // Count the used lengths as their reads come back.
        if (tv_reg && (leff != '0)) begin
            tally_next[leff] = tally_rd + TALLY_W'(1);
        end

        unique case (state_reg)
            ST_CLEAR: begin
                nt_we    = 1'b1;
                nt_waddr = clr_cnt_reg;
                nt_wdata = '0;
                if (clr_cnt_reg == clr_last_reg) begin
                    n_next     = '0;
                    state_next = build_reg ? ST_TALLY : ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + NT_AW'(1);
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_LOAD: begin
                            ls_we = ({1'b0, in_word.symbol_index} < MAX_SYM_V);
                        end
                        CMD_BUILD: begin
                            alpha_next    = nc_sat;
                            ml_next       = ml_sat;
                            wp_next       = '0;
                            for (int k = 0; k < NUM_LENGTHS; k++) begin
                                tally_next[k] = '0;
                            end
                            ncode_next[0] = '0;
                            clr_cnt_next  = '0;
                            clr_last_next = NT_AW'({2'b00, nc_sat, 1'b0} - 12'd1);
                            build_next    = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        CMD_DECODE: begin
                            if (wp_reg >= alpha_ext) begin
                                emit             = 1'b1;
                                emit_word.status = STS_OUTSIDE;
                            end else begin
                                nt_re      = 1'b1;
                                nt_raddr   = {wp_reg[LS_AW-1:0], in_word.code_bit};
                                state_next = ST_DEC_EV;
                            end
                        end
                        CMD_NOP: begin
                            state_next = ST_IDLE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Sweep the length memory, one read issued per cycle.
            ST_TALLY: begin
                ls_re   = 1'b1;
                tv_next = 1'b1;
                if (last_sym) begin
                    state_next = ST_TALLY_END;
                end else begin
                    n_next = n_reg + SYM_W'(1);
                end
            end

            ST_TALLY_END: begin
                b_next     = LEN_W'(1);
                state_next = ST_CODES;
            end

            // First code of each length, one length per cycle.
            ST_CODES: begin
                ncode_next[b_reg] = CODE_W'((ncode_rd
                    + ((b_reg == LEN_W'(1)) ? CODE_W'(0) : CODE_W'(tally_rd))) << 1);
                if (b_reg == LAST_LEN) begin
                    n_next     = '0;
                    pos_next   = '0;
                    nodes_next = '0;
                    state_next = ST_INS_LRD;
                end else begin
                    b_next = b_reg + LEN_W'(1);
                end
            end

            ST_INS_LRD: begin
                ls_re      = 1'b1;
                state_next = ST_INS_LEV;
            end

            // Take the next code of this length or skip an unused symbol.
            ST_INS_LEV: begin
                if (leff == '0) begin
                    if (last_sym) begin
                        emit             = 1'b1;
                        emit_word.status = STS_OK;
                    end else begin
                        n_next     = n_reg + SYM_W'(1);
                        state_next = ST_INS_LRD;
                    end
                end else begin
                    len_next         = leff;
                    code_next        = ncode_rd;
                    ncode_next[leff] = ncode_rd + CODE_W'(1);
                    bi_next          = '0;
                    state_next       = ST_BIT_RD;
                end
            end

            // Read the child entry for the current code bit.
            ST_BIT_RD: begin
                if (pos_reg > alpha_ext - PTR_W'(2)) begin
                    emit             = 1'b1;
                    emit_word.status = STS_OVERRUN;
                end else begin
                    nt_re      = 1'b1;
                    idx_next   = {pos_reg[LS_AW-1:0], cur_bit};
                    state_next = ST_BIT_EV;
                end
            end

            // Fill an empty entry with a leaf or a new link, or follow a filled one.
            ST_BIT_EV: begin
                if (!nt_rdata_reg.filled) begin
                    nt_we           = 1'b1;
                    nt_wdata.filled = 1'b1;
                    if (last_bit) begin
                        nt_wdata.value = PTR_W'(n_reg);
                        pos_next       = '0;
                    end else begin
                        nt_wdata.value = nodes_inc + alpha_ext;
                        pos_next       = nodes_inc;
                        nodes_next     = nodes_inc;
                    end
                end else begin
                    pos_next = nt_rdata_reg.value - alpha_ext;
                end
                if (last_bit) begin
                    if (last_sym) begin
                        emit             = 1'b1;
                        emit_word.status = STS_OK;
                    end else begin
                        n_next     = n_reg + SYM_W'(1);
                        state_next = ST_INS_LRD;
                    end
                end else begin
                    bi_next    = bi_reg + LEN_W'(1);
                    state_next = ST_BIT_RD;
                end
            end

            // One decode step from the entry just read.
            ST_DEC_EV: begin
                emit             = 1'b1;
                emit_word.status = STS_OK;
                if (!nt_rdata_reg.filled) begin
                    wp_next = OUTSIDE_PTR;
                end else if (nt_rdata_reg.value < alpha_ext) begin
                    emit_word.symbol_valid   = 1'b1;
                    emit_word.decoded_symbol = nt_rdata_reg.value[SYM_W-1:0];
                    wp_next                  = '0;
                end else begin
                    wp_next = nt_rdata_reg.value - alpha_ext;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished result goes to the output register, or waits for it.
        if (emit) begin
            if (out_free) begin
                state_next = ST_IDLE;
            end else begin
                res_next   = emit_word;
                state_next = ST_RESP;
            end
        end
    end

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_word_next   = m_word_reg;
        if (emit && out_free) begin
            m_tvalid_next = 1'b1;
            m_word_next   = emit_word;
        end else if ((state_reg == ST_RESP) && out_free) begin
            m_tvalid_next = 1'b1;
            m_word_next   = res_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_last_reg <= CLR_ALL;
            build_reg    <= 1'b0;
            tv_reg       <= 1'b0;
            wp_reg       <= '0;
            alpha_reg    <= ALPHA_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_last_reg <= clr_last_next;
            build_reg    <= build_next;
            tv_reg       <= tv_next;
            wp_reg       <= wp_next;
            alpha_reg    <= alpha_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working registers of the build and the output word.
    always_ff @(posedge aclk) begin
        ml_reg     <= ml_next;
        n_reg      <= n_next;
        b_reg      <= b_next;
        len_reg    <= len_next;
        bi_reg     <= bi_next;
        code_reg   <= code_next;
        pos_reg    <= pos_next;
        nodes_reg  <= nodes_next;
        idx_reg    <= idx_next;
        tally_reg  <= tally_next;
        ncode_reg  <= ncode_next;
        res_reg    <= res_next;
        m_word_reg <= m_word_next;
    end

    // Code-length memory, registered read.
    always_ff @(posedge aclk) begin
        if (ls_we) begin
            ls_mem[ls_waddr] <= ls_wdata;
        end
        if (ls_re) begin
            ls_rdata_reg <= ls_mem[ls_raddr];
        end
    end

    // Node table memory, registered read.
    always_ff @(posedge aclk) begin
        if (nt_we) begin
            nt_mem[nt_waddr] <= nt_wdata;
        end
        if (nt_re) begin
            nt_rdata_reg <= nt_mem[nt_raddr];
        end
    end

endmodule

`default_nettype wire
